// ----- hw/rtl/vad_pkg.sv -----
// Shared widths, fixed-point constants and the arctangent table of the angle pipeline.
package vad_pkg;

  localparam int COORD_BITS      = 16;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int CORDIC_STEPS    = 16;

  localparam int ANGLE_W   = 16;
  localparam int QBITS     = 24;
  // Vector components are shifted up so the largest difference lies just below bit 58.
  localparam int SCALE_SH  = 58 - COORD_BITS;
  localparam int D_W       = COORD_BITS + 2;
  localparam int XY_W      = 62;
  localparam int Z_W       = 33;
  localparam int T_W       = 36;
  localparam int TU_W      = 33;
  localparam int RND_SH    = QBITS - ANGLE_FRAC_BITS;
  localparam int A_W       = TU_W - RND_SH + 1;
  localparam int TABLE_LEN = 14;

  localparam logic [T_W-1:0] FULL_Q = T_W'(360) << QBITS;
  localparam logic [T_W-1:0] HALF_Q = T_W'(180) << QBITS;
  localparam logic [TU_W:0]  RND_Q  = (TU_W+1)'(1) << (RND_SH - 1);
  localparam logic [A_W-1:0] ANGLE_LIM = A_W'(360) << ANGLE_FRAC_BITS;

  // Degree constants: whole part plus twelve decimal digits, rounded to Q24.
  localparam logic [79:0] DSC  = 80'd16777216;
  localparam logic [79:0] DHLF = 80'd500000000000;
  localparam logic [79:0] DONE = 80'd1000000000000;

  localparam logic [79:0] RAD2DEG_Q = (80'd57 << QBITS) + (80'd295779513082 * DSC + DHLF) / DONE;

  localparam logic [79:0] ATAN_TAB [TABLE_LEN] = '{
    (80'd45 << QBITS) + (80'd0 * DSC + DHLF) / DONE,
    (80'd26 << QBITS) + (80'd565051177078 * DSC + DHLF) / DONE,
    (80'd14 << QBITS) + (80'd36243467926 * DSC + DHLF) / DONE,
    (80'd7 << QBITS) + (80'd125016348902 * DSC + DHLF) / DONE,
    (80'd3 << QBITS) + (80'd576334374997 * DSC + DHLF) / DONE,
    (80'd1 << QBITS) + (80'd789910608246 * DSC + DHLF) / DONE,
    (80'd0 << QBITS) + (80'd895173710211 * DSC + DHLF) / DONE,
    (80'd0 << QBITS) + (80'd447614170861 * DSC + DHLF) / DONE,
    (80'd0 << QBITS) + (80'd223810500369 * DSC + DHLF) / DONE,
    (80'd0 << QBITS) + (80'd111905677066 * DSC + DHLF) / DONE,
    (80'd0 << QBITS) + (80'd55952891894 * DSC + DHLF) / DONE,
    (80'd0 << QBITS) + (80'd27976452617 * DSC + DHLF) / DONE,
    (80'd0 << QBITS) + (80'd13988227142 * DSC + DHLF) / DONE,
    (80'd0 << QBITS) + (80'd6994113675 * DSC + DHLF) / DONE
  };

  // Control that travels with each pipeline slot.
  typedef struct packed {
    logic valid;
    logic zero;
    logic flip;
  } vad_ctl_t;

  // atan(2^-idx) in Q24 degrees; small angles use the radian approximation.
  function automatic logic [Z_W-1:0] atan_q(input int unsigned idx);
    logic [79:0] v;
    v = 80'd0;
    if (idx < TABLE_LEN) begin
      v = ATAN_TAB[idx];
    end else begin
      v = (RAD2DEG_Q + (80'd1 << (idx - 1))) >> idx;
    end
    return v[Z_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/vector_angle_degrees.sv -----
// Top level: direction of a pixel vector in degrees, pipelined CORDIC vectoring.
//
//   channel  direction  handshake                 payload
//   input    in         in_valid_i / in_stall_o   start_x_i start_y_i end_x_i end_y_i
//   output   out        out_valid_o / out_stall_i angle_o zero_vector_o
//
// One transaction per cycle while the output is not stalled; stages are one prep stage,
// one stage per micro-rotation and two stages for wrap and rounding.
// Reset clears every slot's valid bit; payload registers are not reset.
// Each stage holds only when it is full and the stage after it holds, so empty
// slots close up behind a stalled output and no transaction is dropped or repeated.
module vector_angle_degrees (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [vad_pkg::COORD_BITS-1:0]    start_x_i,
  input  logic [vad_pkg::COORD_BITS-1:0]    start_y_i,
  input  logic [vad_pkg::COORD_BITS-1:0]    end_x_i,
  input  logic [vad_pkg::COORD_BITS-1:0]    end_y_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [vad_pkg::ANGLE_W-1:0]       angle_o,
  output logic                              zero_vector_o
);

  vad_pkg::vad_ctl_t               prep_ctl, cor_ctl;
  logic signed [vad_pkg::XY_W-1:0] prep_x, prep_y;
  logic signed [vad_pkg::Z_W-1:0]  cor_z;
  logic                            cor_adv, post_adv;

  vad_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .end_x_i    (end_x_i),
    .end_y_i    (end_y_i),
    .adv_i      (cor_adv),
    .ctl_o      (prep_ctl),
    .x_o        (prep_x),
    .y_o        (prep_y)
  );

  vad_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (prep_ctl),
    .x_i    (prep_x),
    .y_i    (prep_y),
    .adv_o  (cor_adv),
    .adv_i  (post_adv),
    .ctl_o  (cor_ctl),
    .z_o    (cor_z)
  );

  vad_post u_post (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (cor_ctl),
    .z_i           (cor_z),
    .adv_o         (post_adv),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .angle_o       (angle_o),
    .zero_vector_o (zero_vector_o)
  );

  a_zero_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_vector_o |-> angle_o == '0)
    else $error("zero vector with nonzero angle");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> angle_o < vad_pkg::ANGLE_W'(vad_pkg::ANGLE_LIM))
    else $error("angle beyond one turn");

  // Backpressure at the input only when the whole pipe is full behind a stalled output.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

endmodule

// ----- hw/rtl/vad_prep.sv -----
// Input stage: point differences, half-plane fold and fixed scaling of the vector.
module vad_prep (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [vad_pkg::COORD_BITS-1:0]    start_x_i,
  input  logic [vad_pkg::COORD_BITS-1:0]    start_y_i,
  input  logic [vad_pkg::COORD_BITS-1:0]    end_x_i,
  input  logic [vad_pkg::COORD_BITS-1:0]    end_y_i,
  input  logic                              adv_i,
  output vad_pkg::vad_ctl_t                 ctl_o,
  output logic signed [vad_pkg::XY_W-1:0]   x_o,
  output logic signed [vad_pkg::XY_W-1:0]   y_o
);

  logic signed [vad_pkg::D_W-1:0]  dx, dy, vx, vy;
  logic                            adv;
  vad_pkg::vad_ctl_t               ctl_q, ctl_d;
  logic signed [vad_pkg::XY_W-1:0] x_q, x_d, y_q, y_d;

  assign adv        = !ctl_q.valid || adv_i;
  assign in_stall_o = !adv;

  always_comb begin
    dx = vad_pkg::D_W'(signed'(end_x_i)) - vad_pkg::D_W'(signed'(start_x_i));
    dy = vad_pkg::D_W'(signed'(end_y_i)) - vad_pkg::D_W'(signed'(start_y_i));
    // Image y points down: flip it, then rotate the left half-plane by 180.
    if (dx[vad_pkg::D_W-1]) begin
      vx = -dx;
      vy = dy;
    end else begin
      vx = dx;
      vy = -dy;
    end
    ctl_d.valid = in_valid_i;
    ctl_d.zero  = (dx == '0) && (dy == '0);
    ctl_d.flip  = dx[vad_pkg::D_W-1];
    x_d = vad_pkg::XY_W'(vx) <<< vad_pkg::SCALE_SH;
    y_d = vad_pkg::XY_W'(vy) <<< vad_pkg::SCALE_SH;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  assign ctl_o = ctl_q;
  assign x_o   = x_q;
  assign y_o   = y_q;

endmodule

// ----- hw/rtl/vad_cordic.sv -----
// CORDIC vectoring pipeline: one micro-rotation per register stage.
module vad_cordic (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  vad_pkg::vad_ctl_t                ctl_i,
  input  logic signed [vad_pkg::XY_W-1:0]  x_i,
  input  logic signed [vad_pkg::XY_W-1:0]  y_i,
  output logic                             adv_o,
  input  logic                             adv_i,
  output vad_pkg::vad_ctl_t                ctl_o,
  output logic signed [vad_pkg::Z_W-1:0]   z_o
);

  localparam int N = vad_pkg::CORDIC_STEPS;

  vad_pkg::vad_ctl_t               ctl_q [N];
  logic signed [vad_pkg::XY_W-1:0] x_q   [N];
  logic signed [vad_pkg::XY_W-1:0] y_q   [N];
  logic signed [vad_pkg::Z_W-1:0]  z_q   [N];
  logic [N:0]                      adv;

  assign adv[N] = adv_i;
  assign adv_o  = adv[0];

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [vad_pkg::Z_W-1:0] ANG = vad_pkg::atan_q(k);

    vad_pkg::vad_ctl_t               c_in;
    logic signed [vad_pkg::XY_W-1:0] x_in, y_in, xs, ys, x_d, y_d;
    logic signed [vad_pkg::Z_W-1:0]  z_in, z_d;

    if (k == 0) begin : g_head
      assign c_in = ctl_i;
      assign x_in = x_i;
      assign y_in = y_i;
      assign z_in = '0;
    end else begin : g_body
      assign c_in = ctl_q[k-1];
      assign x_in = x_q[k-1];
      assign y_in = y_q[k-1];
      assign z_in = z_q[k-1];
    end

    assign adv[k] = !ctl_q[k].valid || adv[k+1];

    always_comb begin
      xs = x_in >>> k;
      ys = y_in >>> k;
      // Rotate toward the x axis, steering on the sign of y.
      if (!y_in[vad_pkg::XY_W-1]) begin
        x_d = x_in + ys;
        y_d = y_in - xs;
        z_d = z_in + signed'(ANG);
      end else begin
        x_d = x_in - ys;
        y_d = y_in + xs;
        z_d = z_in - signed'(ANG);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= '0;
      end else if (adv[k]) begin
        ctl_q[k] <= c_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k]) begin
        x_q[k] <= x_d;
        y_q[k] <= y_d;
        z_q[k] <= z_d;
      end
    end
  end

  assign ctl_o = ctl_q[N-1];
  assign z_o   = z_q[N-1];

endmodule

// ----- hw/rtl/vad_post.sv -----
// Output stages: add the half-turn base for folded vectors, wrap to one turn, round and hold the result.
module vad_post (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  vad_pkg::vad_ctl_t                   ctl_i,
  input  logic signed [vad_pkg::Z_W-1:0]      z_i,
  output logic                                adv_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [vad_pkg::ANGLE_W-1:0]         angle_o,
  output logic                                zero_vector_o
);

  vad_pkg::vad_ctl_t             c1_q, c2_q;
  logic                          adv1, adv2;
  logic signed [vad_pkg::T_W-1:0] t_raw, t_w;
  logic [vad_pkg::TU_W-1:0]      t_q;
  logic [vad_pkg::TU_W:0]        t_rnd;
  logic [vad_pkg::A_W-1:0]       a_raw, a_w;
  logic [vad_pkg::ANGLE_W-1:0]   angle_q, angle_d;

  assign adv2  = !c2_q.valid || !out_stall_i;
  assign adv1  = !c1_q.valid || adv2;
  assign adv_o = adv1;

  always_comb begin
    t_raw = vad_pkg::T_W'(z_i) + (ctl_i.flip ? signed'(vad_pkg::HALF_Q) : '0);
    if (t_raw[vad_pkg::T_W-1]) begin
      t_w = t_raw + signed'(vad_pkg::FULL_Q);
    end else if (t_raw >= signed'(vad_pkg::FULL_Q)) begin
      t_w = t_raw - signed'(vad_pkg::FULL_Q);
    end else begin
      t_w = t_raw;
    end
  end

  always_comb begin
    t_rnd = {1'b0, t_q} + vad_pkg::RND_Q;
    a_raw = t_rnd[vad_pkg::TU_W:vad_pkg::RND_SH];
    // Rounding up to a full turn wraps to zero.
    a_w   = (a_raw >= vad_pkg::ANGLE_LIM) ? a_raw - vad_pkg::ANGLE_LIM : a_raw;
    angle_d = c1_q.zero ? '0 : vad_pkg::ANGLE_W'(a_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
    end else begin
      if (adv1) begin
        c1_q <= ctl_i;
      end
      if (adv2) begin
        c2_q <= c1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      t_q <= t_w[vad_pkg::TU_W-1:0];
    end
    if (adv2) begin
      angle_q <= angle_d;
    end
  end

  assign out_valid_o   = c2_q.valid;
  assign angle_o       = angle_q;
  assign zero_vector_o = c2_q.zero;

endmodule
